// ===== rtl/bmmd_pkg.sv =====
package bmmd_pkg;

    localparam int VRAM_BANKS  = 2;
    localparam int EXRAM_BANKS = 16;
    localparam int WRAM_BANKS  = 8;

    localparam int BIG_BANK    = 8192;
    localparam int SMALL_BANK  = 4096;
    localparam int SPRITE_SIZE = 160;
    localparam int UNUSED_SIZE = 96;
    localparam int IO_SIZE     = 128;
    localparam int HIGH_SIZE   = 127;

    localparam int VID_BASE    = 0;
    localparam int EXT_BASE    = VID_BASE + VRAM_BANKS * BIG_BANK;
    localparam int WORK_BASE   = EXT_BASE + EXRAM_BANKS * BIG_BANK;
    localparam int SPR_BASE    = WORK_BASE + WRAM_BANKS * SMALL_BANK;
    localparam int UNU_BASE    = SPR_BASE + SPRITE_SIZE;
    localparam int IO_BASE     = UNU_BASE + UNUSED_SIZE;
    localparam int HIGH_BASE   = IO_BASE + IO_SIZE;
    localparam int MEM_DEPTH   = HIGH_BASE + HIGH_SIZE;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int VBANK_W     = 1;
    localparam int XBANK_W     = 4;
    localparam int WBANK_W     = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ADDR_W-1:0] ECHO_OFFSET = 16'h2000;
    localparam logic [ADDR_W-1:0] IRQ_ADDR    = 16'hFFFF;
    localparam logic [ADDR_W-1:0] UNU_START   = 16'hFEA0;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VRAM_BANK = 2'd0,
        CFG_EXT_BANK  = 2'd1,
        CFG_WORK_BANK = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REGION_NONE,
        REGION_MEM,
        REGION_IRQ
    } t_region;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_IRQ
    } t_src;

endpackage

// ===== rtl/bmmd_req_if.sv =====
interface bmmd_req_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [bmmd_pkg::ADDR_W-1:0]    address;
    logic [bmmd_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, cmd, address, write_data, input ready);
    modport sink   (input valid, cmd, address, write_data, output ready);
endinterface

// ===== rtl/bmmd_rsp_if.sv =====
interface bmmd_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bmmd_pkg::DATA_W-1:0]    read_data;
    logic                           invalid;

    modport source (output valid, read_data, invalid, input ready);
    modport sink   (input valid, read_data, invalid, output ready);
endinterface

// ===== rtl/banked_memory_map_decoder_top.sv =====
// Banked memory map decoder. Each transaction on i_req is one byte read or write at a
// 16-bit bus address; it is decoded onto the video, external, work, sprite, unusable,
// I/O and high RAM areas (0xE000-0xFDFF echoes 0xC000) and the interrupt-enable register
// at 0xFFFF. All RAM areas share one flat single-port synchronous store with a
// registered read; the address of a transaction is mapped onto it in the cycle it is
// accepted and its response transaction is presented on o_rsp on the next cycle. One
// transaction is accepted per clock; a response stalled on o_rsp holds i_req.ready low
// until it is taken. Bank selects at or above the bank count use the last bank. Addresses
// below 0x8000 answer invalid with read_data 0 and do not write. Writes answer read_data
// 0. RAM contents are undefined until written and no clearing pass runs after reset;
// the interrupt-enable register resets to zero. Bank registers are written on i_cfg_we.
module banked_memory_map_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bmmd_req_if.sink                          i_req,
    bmmd_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [bmmd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bmmd_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [bmmd_pkg::VBANK_W-1:0]   r_vram_bank;
    logic [bmmd_pkg::XBANK_W-1:0]   r_ext_bank;
    logic [bmmd_pkg::WBANK_W-1:0]   r_work_bank;
    logic [bmmd_pkg::DATA_W-1:0]    r_irq;

    logic [bmmd_pkg::DATA_W-1:0]    r_mem [bmmd_pkg::MEM_DEPTH];
    logic [bmmd_pkg::DATA_W-1:0]    r_mem_q;
    logic [bmmd_pkg::DATA_W-1:0]    r_irq_q;
    logic                           r_out_valid;
    logic                           r_invalid;
    bmmd_pkg::t_src                 r_src;

    logic                           in_fire;
    logic [bmmd_pkg::ADDR_W-1:0]    a;
    logic [bmmd_pkg::VBANK_W-1:0]   vb;
    logic [bmmd_pkg::XBANK_W-1:0]   xb;
    logic [bmmd_pkg::WBANK_W-1:0]   wb;
    logic [bmmd_pkg::ADDR_W-1:0]    unu_off;
    logic [bmmd_pkg::MEM_AW-1:0]    phys;
    bmmd_pkg::t_region              region;
    bmmd_pkg::t_src                 n_src;

    assign in_fire     = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    // bank clamping
    assign vb = (int'(r_vram_bank) >= bmmd_pkg::VRAM_BANKS) ?
                bmmd_pkg::VBANK_W'(bmmd_pkg::VRAM_BANKS - 1) : r_vram_bank;
    assign xb = (int'(r_ext_bank) >= bmmd_pkg::EXRAM_BANKS) ?
                bmmd_pkg::XBANK_W'(bmmd_pkg::EXRAM_BANKS - 1) : r_ext_bank;
    assign wb = (int'(r_work_bank) >= bmmd_pkg::WRAM_BANKS) ?
                bmmd_pkg::WBANK_W'(bmmd_pkg::WRAM_BANKS - 1) : r_work_bank;

    assign unu_off = a - bmmd_pkg::UNU_START;

    // address decode
    always_comb begin
        a      = i_req.address;
        phys   = '0;
        region = bmmd_pkg::REGION_NONE;
        if (i_req.address inside {[16'hE000:16'hFDFF]}) begin
            a = i_req.address - bmmd_pkg::ECHO_OFFSET;
        end
        if (a inside {[16'h8000:16'h9FFF]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::VID_BASE)
                   + (bmmd_pkg::MEM_AW'(vb) << 13) + bmmd_pkg::MEM_AW'(a[12:0]);
        end else if (a inside {[16'hA000:16'hBFFF]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::EXT_BASE)
                   + (bmmd_pkg::MEM_AW'(xb) << 13) + bmmd_pkg::MEM_AW'(a[12:0]);
        end else if (a inside {[16'hC000:16'hCFFF]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::WORK_BASE) + bmmd_pkg::MEM_AW'(a[11:0]);
        end else if (a inside {[16'hD000:16'hDFFF]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::WORK_BASE)
                   + (bmmd_pkg::MEM_AW'(wb) << 12) + bmmd_pkg::MEM_AW'(a[11:0]);
        end else if (a inside {[16'hFE00:16'hFE9F]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::SPR_BASE) + bmmd_pkg::MEM_AW'(a[7:0]);
        end else if (a inside {[16'hFEA0:16'hFEFF]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::UNU_BASE) + bmmd_pkg::MEM_AW'(unu_off[6:0]);
        end else if (a inside {[16'hFF00:16'hFF7F]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::IO_BASE) + bmmd_pkg::MEM_AW'(a[6:0]);
        end else if (a inside {[16'hFF80:16'hFFFE]}) begin
            region = bmmd_pkg::REGION_MEM;
            phys   = bmmd_pkg::MEM_AW'(bmmd_pkg::HIGH_BASE) + bmmd_pkg::MEM_AW'(a[6:0]);
        end else if (a == bmmd_pkg::IRQ_ADDR) begin
            region = bmmd_pkg::REGION_IRQ;
        end
    end

    always_comb begin
        n_src = bmmd_pkg::SRC_ZERO;
        if (i_req.cmd == bmmd_pkg::CMD_READ) begin
            case (region)
                bmmd_pkg::REGION_MEM: n_src = bmmd_pkg::SRC_MEM;
                bmmd_pkg::REGION_IRQ: n_src = bmmd_pkg::SRC_IRQ;
                default:              n_src = bmmd_pkg::SRC_ZERO;
            endcase
        end
    end

    // flat store
    always_ff @(posedge i_clk) begin
        if (in_fire && region == bmmd_pkg::REGION_MEM) begin
            if (i_req.cmd == bmmd_pkg::CMD_WRITE) begin
                r_mem[phys] <= i_req.write_data;
            end else begin
                r_mem_q <= r_mem[phys];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_irq_q   <= r_irq;
            r_src     <= n_src;
            r_invalid <= (region == bmmd_pkg::REGION_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_irq       <= '0;
            r_vram_bank <= '0;
            r_ext_bank  <= '0;
            r_work_bank <= bmmd_pkg::WBANK_W'(1);
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && region == bmmd_pkg::REGION_IRQ
                    && i_req.cmd == bmmd_pkg::CMD_WRITE) begin
                r_irq <= i_req.write_data;
            end
            if (i_cfg_we) begin
                case (bmmd_pkg::t_cfg_idx'(i_cfg_index))
                    bmmd_pkg::CFG_VRAM_BANK: r_vram_bank <= i_cfg_data[bmmd_pkg::VBANK_W-1:0];
                    bmmd_pkg::CFG_EXT_BANK:  r_ext_bank  <= i_cfg_data[bmmd_pkg::XBANK_W-1:0];
                    bmmd_pkg::CFG_WORK_BANK: r_work_bank <= i_cfg_data[bmmd_pkg::WBANK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // response transaction
    always_comb begin
        case (r_src)
            bmmd_pkg::SRC_MEM: o_rsp.read_data = r_mem_q;
            bmmd_pkg::SRC_IRQ: o_rsp.read_data = r_irq_q;
            default:           o_rsp.read_data = '0;
        endcase
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.invalid = r_invalid;

    a_accept_gives_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_rsp.valid)
        else $error("accepted transaction produced no response");

    a_invalid_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.invalid |-> o_rsp.read_data == '0)
        else $error("invalid response carries nonzero data");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("input accepted while response stalled");

    a_irq_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_req.cmd == bmmd_pkg::CMD_WRITE && i_req.address == bmmd_pkg::IRQ_ADDR
        |=> r_irq == $past(i_req.write_data))
        else $error("interrupt-enable write lost");

endmodule
